FILE: design/psmh_pkg.sv
package psmh_pkg;

	// Hash constants
	localparam logic [31:0] TAIL_WORD0 = 32'h9BFE_8468;
	localparam logic [31:0] TAIL_WORD1 = 32'h66F4_0C58;
	localparam logic [31:0] KEY_XOR    = 32'h267B_0B11;
	localparam logic [31:0] M1_AND     = 32'hBDEB_77DE;
	localparam logic [31:0] M1_OR      = 32'h0204_0801;
	localparam logic [31:0] M2_AND     = 32'h7D7E_BBDE;
	localparam logic [31:0] M2_OR      = 32'h0080_4021;
	localparam logic [31:0] RESET_A    = 32'h7759_799B;
	localparam logic [31:0] RESET_B    = 32'h37A3_170E;
	localparam logic [31:0] RESET_KEY  = 32'hF4F7_0C38;

	// Default limit on the number of words that count
	localparam int MAX_WORDS_DEF = 64;

	// Digit-serial multiplier geometry
	localparam int WORD_W     = 32;
	localparam int DIGIT_W    = 4;
	localparam int NUM_DIGITS = WORD_W / DIGIT_W;
	localparam int DCNT_W     = $clog2(NUM_DIGITS);
	localparam int PSUM_W     = WORD_W + DIGIT_W;

	// Character codes used by the folding step
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_CASE    = 8'h20;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_NUL     = 8'h00;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_MUL,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		RND_WORD,
		RND_TAIL0,
		RND_TAIL1
	} rnd_t;

endpackage

FILE: design/path_string_mix_hash.sv
// String mixing hash.
// The input channel (in_valid, in_stall, char_byte, last) carries one byte per
// transaction. Upper-case letters fold to lower case and '/' becomes '\'.
// Bytes pack little-endian into 32-bit words; only the first 4*MAX_WORDS bytes
// count, and a zero byte ends the string early. The transaction with last set
// ends the string and yields one hash on the output channel (out_valid,
// out_stall, hash); other transactions yield nothing.
// A byte that does not complete a word is taken and needs no round. A byte that
// completes a word is taken and then starts a mixing round (a set-up state, the
// 32x4 digit multiplier working through the eight 4-bit digits of the multiplier,
// then a state that folds the products). The last transaction runs up to three
// rounds, and the hash is valid in the cycle after the final round.
// Reset clears the block to its initial hash state with no hash pending.
// The result sits in an output register, so the block goes on taking bytes
// while it waits; only the final round of the next string waits for the
// receiver to take the previous hash.
module path_string_mix_hash
	import psmh_pkg::*;
#(
	parameter int MAX_WORDS = MAX_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_byte,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] hash
);

	localparam int WCNT_W = $clog2(MAX_WORDS + 1);

	state_t state_q, state_d;
	rnd_t   rnd_q;

	logic [31:0]       acc_a_q, acc_b_q, rot_q;
	logic [31:0]       wbuf_q;
	logic [1:0]        pos_q;
	logic [WCNT_W-1:0] wcnt_q;
	logic              ended_q;
	logic              fin_q;
	logic [31:0]       w_q;
	logic [31:0]       ea_q, eb_q;
	logic [31:0]       h1_q, l1_q, h2_q, l2_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [31:0]       hash_q;
	logic              out_valid_q;

	logic        do_accept, fin_go, out_take;
	logic [7:0]  ch_fold;
	logic        take, word_done, need_word;
	logic [31:0] eff_buf;
	logic [1:0]  eff_pos;
	logic [31:0] rot_new, key_t, ea_new, eb_new, m1, m2;
	logic [PSUM_W-1:0] psum1, psum2;
	logic [31:0] new_a, new_b;

	// Handshake and sequencing strobes
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		do_accept = in_valid && (state_q == ST_IDLE);
		out_take  = out_valid_q && !out_stall;
		fin_go    = (state_q == ST_FIN) &&
			!((rnd_q == RND_TAIL1) && out_valid_q && out_stall);
	end

	assign out_valid = out_valid_q;
	assign hash      = hash_q;

	// Byte folding and word packing for the incoming transaction
	always_comb begin
		ch_fold = char_byte;
		if (char_byte inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
			ch_fold = char_byte + CH_CASE;
		end else if (char_byte == CH_SLASH) begin
			ch_fold = CH_BSLASH;
		end
		take    = !ended_q && (char_byte != CH_NUL) && (wcnt_q < WCNT_W'(MAX_WORDS));
		eff_buf = wbuf_q;
		eff_pos = pos_q;
		if (take) begin
			eff_buf[{pos_q, 3'b000} +: 8] = ch_fold;
			eff_pos = pos_q + 2'd1;
		end
		word_done = take && (pos_q == 2'd3);
		need_word = word_done || (last && (eff_pos != 2'd0));
	end

	// Round set-up: rotate the key and form multiplicands and multipliers
	always_comb begin
		rot_new = {rot_q[30:0], rot_q[31]};
		key_t   = rot_new ^ KEY_XOR;
		ea_new  = w_q ^ acc_a_q;
		eb_new  = w_q ^ acc_b_q;
		m1      = ((key_t + ea_new) & M1_AND) | M1_OR;
		m2      = ((key_t + eb_new) & M2_AND) | M2_OR;
	end

	// One multiplier digit per cycle for each product
	always_comb begin
		psum1 = PSUM_W'(h1_q) + PSUM_W'(eb_q) * PSUM_W'(l1_q[DIGIT_W-1:0]);
		psum2 = PSUM_W'(h2_q) + PSUM_W'(ea_q) * PSUM_W'(l2_q[DIGIT_W-1:0]);
	end

	// Fold the finished products into the accumulators
	always_comb begin
		new_b = (h1_q != 32'd0) ? (h1_q + l1_q + 32'd1) : l1_q;
		new_a = (h2_q != 32'd0) ? (l2_q + {h2_q[30:0], 1'b0} + 32'd2) : l2_q;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (do_accept && (need_word || last)) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				if (dcnt_q == DCNT_W'(NUM_DIGITS - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (fin_go) begin
					if ((rnd_q == RND_WORD) && !fin_q) begin
						state_d = ST_IDLE;
					end else if (rnd_q == RND_TAIL1) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_SETUP;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hash state, string packing and round sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_a_q     <= RESET_A;
			acc_b_q     <= RESET_B;
			rot_q       <= RESET_KEY;
			wbuf_q      <= '0;
			pos_q       <= '0;
			wcnt_q      <= '0;
			ended_q     <= 1'b0;
			fin_q       <= 1'b0;
			rnd_q       <= RND_WORD;
			out_valid_q <= 1'b0;
		end else begin
			// A new hash may replace one that is taken in the same cycle.
			if (fin_go && (rnd_q == RND_TAIL1)) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			if (do_accept) begin
				fin_q <= last;
				if (last) begin
					wbuf_q  <= '0;
					pos_q   <= '0;
					wcnt_q  <= '0;
					ended_q <= 1'b0;
				end else begin
					wbuf_q  <= word_done ? 32'd0 : eff_buf;
					pos_q   <= eff_pos;
					wcnt_q  <= word_done ? (wcnt_q + WCNT_W'(1)) : wcnt_q;
					ended_q <= ended_q || (char_byte == CH_NUL);
				end
				rnd_q <= need_word ? RND_WORD : RND_TAIL0;
			end
			if (state_q == ST_SETUP) begin
				rot_q <= rot_new;
			end
			if (fin_go) begin
				case (rnd_q)
					RND_WORD: begin
						acc_a_q <= new_a;
						acc_b_q <= new_b;
						rnd_q   <= RND_TAIL0;
					end
					RND_TAIL0: begin
						acc_a_q <= new_a;
						acc_b_q <= new_b;
						rnd_q   <= RND_TAIL1;
					end
					RND_TAIL1: begin
						acc_a_q <= RESET_A;
						acc_b_q <= RESET_B;
						rot_q   <= RESET_KEY;
						fin_q   <= 1'b0;
						rnd_q   <= RND_WORD;
					end
					default: begin
						rnd_q <= RND_WORD;
					end
				endcase
			end
		end
	end

	// Digit counter of the multiplier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (state_q == ST_MUL) begin
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end else begin
			dcnt_q <= '0;
		end
	end

	// Datapath registers: round word, operands, partial products and result
	always_ff @(posedge clk) begin
		if (do_accept) begin
			w_q <= need_word ? eff_buf : TAIL_WORD0;
		end
		if (fin_go) begin
			if (rnd_q == RND_TAIL0) begin
				w_q <= TAIL_WORD1;
			end else begin
				w_q <= TAIL_WORD0;
			end
			if (rnd_q == RND_TAIL1) begin
				hash_q <= new_a ^ new_b;
			end
		end
		case (state_q)
			ST_SETUP: begin
				ea_q <= ea_new;
				eb_q <= eb_new;
				h1_q <= '0;
				h2_q <= '0;
				l1_q <= m1;
				l2_q <= m2;
			end
			ST_MUL: begin
				h1_q <= psum1[PSUM_W-1:DIGIT_W];
				h2_q <= psum2[PSUM_W-1:DIGIT_W];
				l1_q <= {psum1[DIGIT_W-1:0], l1_q[WORD_W-1:DIGIT_W]};
				l2_q <= {psum2[DIGIT_W-1:0], l2_q[WORD_W-1:DIGIT_W]};
			end
			default: begin
			end
		endcase
	end

	// Checks on sequencing
	a_out_from_tail: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN && rnd_q == RND_TAIL1))
		else $error("hash presented without a final tail round");

	a_wcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wcnt_q <= WCNT_W'(MAX_WORDS))
		else $error("word count beyond limit");

	a_mul_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && dcnt_q == DCNT_W'(NUM_DIGITS - 1)) |=> state_q == ST_FIN)
		else $error("multiplier did not finish after all digits");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && last) |=> in_stall)
		else $error("final transaction did not start tail rounds");

endmodule
